// ===== design/spr_pkg.sv =====
// Shared constants and types for the servo pulse ramp generator.
package spr_pkg;

    // Pulse limits and conversion
    localparam int unsigned PULSE_MIN_US   = 800;
    localparam int unsigned PULSE_MAX_US   = 2500;
    localparam int unsigned NS_PER_US      = 1000;
    localparam int unsigned PULSE_RESET_US = 1500;
    localparam int unsigned PERIOD_RESET   = 20000000;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned US_W     = 16;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned PULSE_W  = 12;
    localparam int unsigned DUTY_W   = 22;
    localparam int unsigned PERIOD_W = 27;
    localparam int unsigned CFG_IDX_W = 1;

    // Serial divider: numerator 2*mag*done + total spans 33 bits
    localparam int unsigned DIV_NUM_W = 2 * MS_W + 1;
    localparam int unsigned DIV_DEN_W = MS_W + 1;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

    // Command codes of an input item
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_DIRECT = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 1'd0,
        REG_PERIOD = 1'd1
    } t_reg;

endpackage

// ===== design/servo_pulse_ramp.sv =====
// Servo pulse ramp generator: direct set, ramp target and tick commands.
//
// Each input item carries one command and yields exactly one result item.
// An enabled tick during a ramp steps through ST_MUL, ST_DIV, ST_FIN and
// ST_DRIVE: ST_MUL forms the 16x16 product of ramp span and elapsed time,
// ST_DIV runs a restoring divider that retires one quotient bit per cycle
// to round the interpolated pulse, and ST_FIN and ST_DRIVE rebase and clamp
// it. Other commands go to ST_OUT directly, or via ST_DRIVE if they write
// a duty. The block takes one item at a time and holds o_stall high
// until the result item has been taken. Configuration writes are taken in
// any cycle (o_cfg_ready is always high) and should only be issued while
// the block is idle; a new period applies at the next duty write.
module servo_pulse_ramp
    import spr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [US_W-1:0]      i_value_us,
    input  logic [MS_W-1:0]      i_ramp_ms,
    input  logic [MS_W-1:0]      i_elapsed_ms,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DUTY_W-1:0]    o_duty_ns,
    output logic [PULSE_W-1:0]   o_pulse_us,
    output logic                 o_duty_written,
    output logic                 o_ramp_active
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DRIVE,
        ST_OUT
    } t_state;

    t_state                r_state,   n_state;
    logic                  r_enable,  n_enable;
    logic [PERIOD_W-1:0]   r_period,  n_period;
    logic [PULSE_W-1:0]    r_current, n_current;
    logic [US_W-1:0]       r_target,  n_target;
    logic [US_W-1:0]       r_start,   n_start;
    logic [MS_W-1:0]       r_total,   n_total;
    logic [MS_W-1:0]       r_left,    n_left;
    logic [DUTY_W-1:0]     r_duty,    n_duty;
    logic                  r_written, n_written;
    logic [US_W+1:0]       r_req,     n_req;
    logic                  r_neg,     n_neg;
    logic [DIV_NUM_W-1:0]  r_num,     n_num;
    logic [DIV_DEN_W-1:0]  r_rem,     n_rem;
    logic [DIV_CNT_W-1:0]  r_cnt,     n_cnt;

    // Ramp arithmetic
    logic [US_W:0]         diff;
    logic [US_W-1:0]       mag;
    logic [MS_W-1:0]       done;
    logic [2*MS_W-1:0]     prod;
    logic [DIV_DEN_W-1:0]  den;
    logic [DIV_DEN_W:0]    shifted;
    logic                  div_ge;
    logic [DIV_DEN_W:0]    sub;

    // Clamp and conversion
    logic [PULSE_W-1:0]    clamped;
    logic [DUTY_W-1:0]     duty_full;
    logic [DUTY_W-1:0]     duty_capped;
    logic [PERIOD_W-1:0]   period_m1;

    assign diff = {1'b0, r_target} - {1'b0, r_start};
    assign mag  = diff[US_W] ? 16'(17'd0 - diff) : diff[US_W-1:0];
    assign done = r_total - r_left;
    assign prod = mag * done;
    assign den  = {r_total, 1'b0};

    // One restoring division step
    assign shifted = {r_rem, r_num[DIV_NUM_W-1]};
    assign div_ge  = shifted >= {1'b0, den};
    assign sub     = shifted - {1'b0, den};

    // Clamp the requested pulse and cap its duty below a nonzero period
    always_comb begin
        if (r_req[US_W+1] || (r_req < 18'(PULSE_MIN_US))) begin
            clamped = PULSE_W'(PULSE_MIN_US);
        end else if (r_req > 18'(PULSE_MAX_US)) begin
            clamped = PULSE_W'(PULSE_MAX_US);
        end else begin
            clamped = r_req[PULSE_W-1:0];
        end
    end

    assign duty_full = {10'd0, clamped} * DUTY_W'(NS_PER_US);
    assign period_m1 = r_period - PERIOD_W'(1);

    always_comb begin
        if ({5'd0, duty_full} >= r_period) begin
            duty_capped = (r_period == '0) ? '0 : period_m1[DUTY_W-1:0];
        end else begin
            duty_capped = duty_full;
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_enable  = r_enable;
        n_period  = r_period;
        n_current = r_current;
        n_target  = r_target;
        n_start   = r_start;
        n_total   = r_total;
        n_left    = r_left;
        n_duty    = r_duty;
        n_written = r_written;
        n_req     = r_req;
        n_neg     = r_neg;
        n_num     = r_num;
        n_rem     = r_rem;
        n_cnt     = r_cnt;

        // take configuration writes
        if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_ENABLE: n_enable = i_cfg_data[0];
                REG_PERIOD: n_period = i_cfg_data;
                default:    n_period = r_period;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_written = 1'b0;
                    n_state   = ST_OUT;
                    unique case (t_cmd'(i_command))
                        CMD_DIRECT: begin
                            if (r_enable) begin
                                n_req   = {2'b00, i_value_us};
                                n_state = ST_DRIVE;
                            end
                        end
                        CMD_TARGET: begin
                            n_target = i_value_us;
                            n_start  = {4'd0, r_current};
                            n_total  = (i_ramp_ms == '0) ? MS_W'(1) : i_ramp_ms;
                            n_left   = (i_ramp_ms == '0) ? MS_W'(1) : i_ramp_ms;
                        end
                        CMD_TICK: begin
                            if (r_enable) begin
                                if (r_left == '0) begin
                                    if ({4'd0, r_current} != r_target) begin
                                        n_req   = {2'b00, r_target};
                                        n_state = ST_DRIVE;
                                    end
                                end else begin
                                    n_left  = (i_elapsed_ms >= r_left) ? '0
                                                                       : r_left - i_elapsed_ms;
                                    n_state = ST_MUL;
                                end
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end
            ST_MUL: begin
                // load numerator 2*mag*done + total for a half-up rounded quotient
                n_num   = {prod, 1'b0} + {17'd0, r_total};
                n_neg   = diff[US_W];
                n_rem   = '0;
                n_cnt   = DIV_CNT_W'(DIV_NUM_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = div_ge ? sub[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
                n_num = {r_num[DIV_NUM_W-2:0], div_ge};
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // rebase the rounded step on the ramp start
                n_req   = r_neg ? {2'b00, r_start} - {2'b00, r_num[US_W-1:0]}
                                : {2'b00, r_start} + {2'b00, r_num[US_W-1:0]};
                n_state = ST_DRIVE;
            end
            ST_DRIVE: begin
                n_current = clamped;
                n_duty    = duty_capped;
                n_written = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_enable  <= 1'b0;
            r_period  <= PERIOD_W'(PERIOD_RESET);
            r_current <= PULSE_W'(PULSE_RESET_US);
            r_target  <= US_W'(PULSE_RESET_US);
            r_start   <= US_W'(PULSE_RESET_US);
            r_total   <= MS_W'(1);
            r_left    <= '0;
            r_duty    <= DUTY_W'(PULSE_RESET_US * NS_PER_US);
            r_written <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_enable  <= n_enable;
            r_period  <= n_period;
            r_current <= n_current;
            r_target  <= n_target;
            r_start   <= n_start;
            r_total   <= n_total;
            r_left    <= n_left;
            r_duty    <= n_duty;
            r_written <= n_written;
        end
        r_req <= n_req;
        r_neg <= n_neg;
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_duty_ns      = r_duty;
    assign o_pulse_us     = r_current;
    assign o_duty_written = r_written;
    assign o_ramp_active  = (r_left != '0);

endmodule

// ===== design/spr_checker.sv =====
// Port-level checks for the servo pulse ramp generator and their binding.
module spr_checker
    import spr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [DUTY_W-1:0]    o_duty_ns,
    input logic [PULSE_W-1:0]   o_pulse_us,
    input logic                 o_duty_written
);

    // A stalled result item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_duty_ns) && $stable(o_pulse_us)
                                  && $stable(o_duty_written)))
        else $error("stalled result item changed");

    // An accepted item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting an item");

    // A result is never shown while a new item can be taken
    a_out_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while accepting items");

    // A written duty always comes from a clamped pulse
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_duty_written) |-> ((o_pulse_us >= PULSE_W'(PULSE_MIN_US))
                                         && (o_pulse_us <= PULSE_W'(PULSE_MAX_US))))
        else $error("written pulse outside clamp range");

endmodule

bind servo_pulse_ramp spr_checker u_spr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_duty_ns      (o_duty_ns),
    .o_pulse_us     (o_pulse_us),
    .o_duty_written (o_duty_written)
);

// ===== tb/sv/servo_pulse_ramp_tb.sv =====
// Self-checking testbench for the servo pulse ramp generator.
module servo_pulse_ramp_tb;
    import spr_pkg::*;

    // Command code that the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned ITEM_GOAL = 1550;
    localparam int unsigned SETTLE_CYCLES = 40;

    // One expected result item
    typedef struct {
        logic [DUTY_W-1:0]  duty_ns;
        logic [PULSE_W-1:0] pulse_us;
        logic               written;
        logic               ramping;
    } t_pulse_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PERIOD_W-1:0]  i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [CMD_W-1:0]     i_command;
    logic [US_W-1:0]      i_value_us;
    logic [MS_W-1:0]      i_ramp_ms;
    logic [MS_W-1:0]      i_elapsed_ms;
    logic                 o_valid;
    logic                 i_stall;
    logic [DUTY_W-1:0]    o_duty_ns;
    logic [PULSE_W-1:0]   o_pulse_us;
    logic                 o_duty_written;
    logic                 o_ramp_active;

    // Predicted channel state and registers
    int unsigned chan_en     = 0;
    int unsigned chan_period = PERIOD_RESET;
    int unsigned cur_us      = PULSE_RESET_US;
    int unsigned tgt_us      = PULSE_RESET_US;
    int unsigned start_us    = PULSE_RESET_US;
    int unsigned total_ms    = 1;
    int unsigned left_ms     = 0;
    int unsigned duty_hold   = PULSE_RESET_US * NS_PER_US;

    t_pulse_report pending_pulses[$];

    bit          tx_quiet;
    bit          rx_quiet;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned duty_writes;
    int unsigned targets_set;
    int unsigned cfg_writes;
    int unsigned errors;

    servo_pulse_ramp u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value_us    (i_value_us),
        .i_ramp_ms     (i_ramp_ms),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_duty_ns     (o_duty_ns),
        .o_pulse_us    (o_pulse_us),
        .o_duty_written(o_duty_written),
        .o_ramp_active (o_ramp_active)
    );

    // Run the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Random 16-bit field value
    function automatic logic [15:0] rand_word();
        return 16'($urandom);
    endfunction

    // Clamp, convert to ns, cap at the period and hold as the new duty
    function automatic void apply_pulse(input int unsigned us);
        int unsigned duty;
        if (us < PULSE_MIN_US) us = PULSE_MIN_US;
        if (us > PULSE_MAX_US) us = PULSE_MAX_US;
        duty = us * NS_PER_US;
        if (duty >= chan_period)
            duty = (chan_period == 0) ? 0 : chan_period - 1;
        duty_hold = duty & 32'h003F_FFFF;
        cur_us    = us;
    endfunction

    // Interpolated pulse, rounded half away from zero
    function automatic int unsigned ramp_pulse();
        longint tot;
        longint done;
        longint diff;
        longint mag;
        longint quo;
        longint res;
        tot  = (total_ms == 0) ? 1 : total_ms;
        done = tot - longint'(left_ms);
        diff = longint'(tgt_us) - longint'(start_us);
        mag  = ((diff < 0) ? -diff : diff) * done;
        quo  = (2 * mag + tot) / (2 * tot);
        res  = (diff < 0) ? longint'(start_us) - quo : longint'(start_us) + quo;
        if (res < 0) res = 0;
        return unsigned'(32'(res));
    endfunction

    // Advance the predicted channel by one item and form its result
    function automatic t_pulse_report advance_servo(input logic [CMD_W-1:0] cmd,
                                                    input logic [US_W-1:0]  value,
                                                    input logic [MS_W-1:0]  ramp,
                                                    input logic [MS_W-1:0]  elapsed);
        t_pulse_report rep;
        logic          wrote;
        wrote = 1'b0;
        case (cmd)
            CMD_DIRECT: begin
                if (chan_en != 0) begin
                    apply_pulse(value);
                    wrote = 1'b1;
                end
            end
            CMD_TARGET: begin
                tgt_us   = value;
                start_us = cur_us;
                total_ms = (ramp == 0) ? 1 : ramp;
                left_ms  = total_ms;
            end
            CMD_TICK: begin
                if (chan_en != 0) begin
                    if (left_ms == 0) begin
                        if (cur_us != tgt_us) begin
                            apply_pulse(tgt_us);
                            wrote = 1'b1;
                        end
                    end else begin
                        left_ms = (elapsed >= left_ms) ? 0 : left_ms - elapsed;
                        apply_pulse(ramp_pulse());
                        wrote = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rep.duty_ns  = duty_hold[DUTY_W-1:0];
        rep.pulse_us = cur_us[PULSE_W-1:0];
        rep.written  = wrote;
        rep.ramping  = (left_ms != 0);
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // Send one item after a random gap; valid stays high until the caller moves on
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [US_W-1:0] value,
                             input logic [MS_W-1:0] ramp, input logic [MS_W-1:0] elapsed);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_value_us   <= value;
        i_ramp_ms    <= ramp;
        i_elapsed_ms <= elapsed;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_pulses.push_back(advance_servo(cmd, value, ramp, elapsed));
        items_sent++;
        if (cmd == CMD_TARGET) targets_set++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_results();
        if (i_valid) i_valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_channel(input logic en, input logic [PERIOD_W-1:0] period);
        logic [31:0] bits;
        drain_results();
        bits    = $urandom;
        bits[0] = en;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ENABLE;
        i_cfg_data  <= bits[PERIOD_W-1:0];
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        chan_en = en;
        i_cfg_index <= REG_PERIOD;
        i_cfg_data  <= period;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        chan_period = period;
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Reset state: tick, direct set and unused code do nothing; a target still lands
    task automatic test_disabled_channel();
        send_item(CMD_TICK, rand_word(), rand_word(), rand_word());
        send_item(CMD_DIRECT, 16'd2000, rand_word(), rand_word());
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_TARGET, 16'd2000, 16'd10, rand_word());
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd5);
    endtask

    // Direct set at the clamp limits and the field extremes
    task automatic test_direct_set();
        set_channel(1'b1, PERIOD_W'(PERIOD_RESET));
        send_item(CMD_DIRECT, 16'd0, 16'd0, 16'd0);
        send_item(CMD_DIRECT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_DIRECT, 16'd2500, rand_word(), rand_word());
        send_item(CMD_DIRECT, 16'd800, rand_word(), rand_word());
    endtask

    // Zero ramp, zero elapsed, overshoot, half-way rounding, target beyond clamp
    task automatic test_ramp_cases();
        send_item(CMD_TARGET, 16'd1700, 16'd0, rand_word());
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd0);
        send_item(CMD_TICK, rand_word(), rand_word(), 16'hFFFF);
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd3);
        send_item(CMD_TARGET, 16'd1701, 16'd2, rand_word());
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd1);
        send_item(CMD_TARGET, 16'd1700, 16'd2, rand_word());
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd1);
        send_item(CMD_TARGET, 16'hFFFF, 16'hFFFF, rand_word());
        send_item(CMD_TICK, rand_word(), rand_word(), 16'hFFFE);
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd1);
        send_item(CMD_TICK, rand_word(), rand_word(), 16'd0);
    endtask

    // Period cap, zero period and a period change that waits for the next write
    task automatic test_period_limits();
        set_channel(1'b1, 27'd1600000);
        send_item(CMD_UNUSED, rand_word(), rand_word(), rand_word());
        send_item(CMD_DIRECT, 16'd2000, rand_word(), rand_word());
        set_channel(1'b1, 27'd0);
        send_item(CMD_DIRECT, 16'd900, rand_word(), rand_word());
        set_channel(1'b1, {PERIOD_W{1'b1}});
        send_item(CMD_DIRECT, 16'd2500, rand_word(), rand_word());
        set_channel(1'b1, 27'd1);
        send_item(CMD_DIRECT, 16'd1200, rand_word(), rand_word());
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0, 1, 2: return PERIOD_W'(PERIOD_RESET);
            3:       return 27'd0;
            4:       return 27'd1;
            5:       return {PERIOD_W{1'b1}};
            6, 7:    return PERIOD_W'($urandom_range(800000, 2500001));
            8:       return PERIOD_W'($urandom_range(1, 100000000));
            default: return PERIOD_W'($urandom);
        endcase
    endfunction

    // One target set followed by a run of ticks
    task automatic run_ramp_sequence();
        logic [US_W-1:0] value;
        logic [MS_W-1:0] ramp;
        logic [MS_W-1:0] elapsed;
        int unsigned     ticks;
        value = ($urandom_range(0, 4) != 0) ? US_W'($urandom_range(700, 2600)) : rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: ramp = MS_W'($urandom_range(0, 40));
            7, 8:                ramp = MS_W'($urandom_range(41, 3000));
            default:             ramp = rand_word();
        endcase
        send_item(CMD_TARGET, value, ramp, rand_word());
        ticks = $urandom_range(1, 8);
        repeat (ticks) begin
            if ($urandom_range(0, 7) != 0)
                elapsed = MS_W'($urandom_range(0, ramp / 4 + 1));
            else
                elapsed = rand_word();
            send_item(CMD_TICK, rand_word(), rand_word(), elapsed);
        end
    endtask

    // A stray item of any command with random fields
    task automatic send_noise();
        logic [CMD_W-1:0] cmd;
        logic [US_W-1:0]  value;
        cmd   = CMD_W'($urandom_range(0, 3));
        value = ($urandom_range(0, 1) != 0) ? US_W'($urandom_range(700, 2600)) : rand_word();
        send_item(cmd, value, rand_word(), rand_word());
    endtask

    // Phases of random ramps under changing register settings
    task automatic test_random_ramps();
        int unsigned phase_end;
        int unsigned choice;
        while (items_sent < ITEM_GOAL) begin
            set_channel(($urandom_range(0, 7) != 0), pick_period());
            phase_end = items_sent + $urandom_range(60, 180);
            while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
                if ($urandom_range(0, 15) == 0) tx_quiet = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 15) == 0) rx_quiet = ($urandom_range(0, 2) == 0);
                choice = $urandom_range(0, 19);
                if (choice < 15)
                    run_ramp_sequence();
                else if (choice == 15)
                    drain_results();
                else
                    send_noise();
            end
        end
    endtask

    // Stall results for a random number of cycles ahead of each one
    initial begin
        int unsigned hold;
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_pulse_report want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_pulses.size() == 0) begin
                report_mismatch("result with nothing pending, pulse_us", o_pulse_us, 0);
            end else begin
                want = pending_pulses.pop_front();
                if (o_duty_ns !== want.duty_ns)
                    report_mismatch("duty_ns", o_duty_ns, want.duty_ns);
                if (o_pulse_us !== want.pulse_us)
                    report_mismatch("pulse_us", o_pulse_us, want.pulse_us);
                if (o_duty_written !== want.written)
                    report_mismatch("duty_written", o_duty_written, want.written);
                if (o_ramp_active !== want.ramping)
                    report_mismatch("ramp_active", o_ramp_active, want.ramping);
            end
            results_seen++;
            if (o_duty_written === 1'b1) duty_writes++;
        end
    end

    // Bound the run
    initial begin
        #20000000;
        $display("servo_pulse_ramp_tb: errors");
        $finish;
    end

    // Reset, then run each test in turn
    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_TICK;
        i_value_us   <= '0;
        i_ramp_ms    <= '0;
        i_elapsed_ms <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_ENABLE;
        i_cfg_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_channel();
        test_direct_set();
        test_ramp_cases();
        test_period_limits();
        test_random_ramps();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d items sent, %0d results checked, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("summary: %0d ramp targets set, %0d duty writes observed",
                 targets_set, duty_writes);
        if (errors == 0)
            $display("servo_pulse_ramp_tb: clean");
        else
            $display("servo_pulse_ramp_tb: errors");
        $finish;
    end

endmodule
